// ----- hdl/conveyor_diverter_sequencer_defines.svh -----
// Assertion macros used by the checker file of the diverter sequencer.
// No dependencies; included by bare file name.
`ifndef CONVEYOR_DIVERTER_SEQUENCER_DEFINES_SVH
`define CONVEYOR_DIVERTER_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CDS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/cds_pkg.sv -----
// Shared constants and codes of the conveyor diverter sequencer.
// No dependencies; used by cds_settle, the top level and the checker by scoped name.
package cds_pkg;

   localparam int SETTLE_MIN_TICKS_DEF = 10;
   localparam int SETTLE_MAX_TICKS_DEF = 160;
   localparam int TIMER_BITS_DEF       = 16;

   localparam int CFG_BITS     = 16;
   localparam int VERDICT_BITS = 8;
   localparam int SETTLE_BITS  = 8;

   localparam logic [CFG_BITS-1:0]     SCAN_LEAD        = 16'd80;
   localparam logic [CFG_BITS-1:0]     PROCESS_TICKS_RST = 16'd300;
   localparam logic [VERDICT_BITS-1:0] VERDICT_ACCEPT   = 8'd1;

   // position check mode
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_OUTER = 2'd1;
   localparam logic [1:0] MODE_INNER = 2'd2;

   // actuation event
   localparam logic [1:0] EVT_NONE  = 2'd0;
   localparam logic [1:0] EVT_OUTER = 2'd1;
   localparam logic [1:0] EVT_INNER = 2'd2;

   // error clear bits
   localparam logic [1:0] CLR_NONE  = 2'd0;
   localparam logic [1:0] CLR_INNER = 2'd1;
   localparam logic [1:0] CLR_OUTER = 2'd2;

   localparam logic DRIVE_INNER = 1'b0;
   localparam logic DRIVE_OUTER = 1'b1;

endpackage

// ----- hdl/cds_settle.sv -----
// One side's baffle position check counter.
// Depends on cds_pkg for the counter width.
module cds_settle #(
   parameter int SETTLE_MIN_TICKS = cds_pkg::SETTLE_MIN_TICKS_DEF,
   parameter int SETTLE_MAX_TICKS = cds_pkg::SETTLE_MAX_TICKS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic sensor,
   output logic done
);

   localparam int CW = cds_pkg::SETTLE_BITS;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW:0]   count_inc;

   always_comb begin
      count_inc = {1'b0, count_ff} + (CW+1)'(1);
      done      = ((count_inc >= (CW+1)'(SETTLE_MIN_TICKS)) && !sensor) ||
                  (count_inc >= (CW+1)'(SETTLE_MAX_TICKS));
      count_in  = count_ff;
      if (advance) begin
         count_in = done ? '0 : count_inc[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/conveyor_diverter_sequencer.sv -----
// Top level of the conveyor diverter sequencer: tick control and result register.
// Depends on cds_pkg and cds_settle.
//
// Each accepted req_ transaction is one time tick; its rsp_ transaction appears
// in the next cycle from the result register. A tick can be taken every cycle:
// the control step, timer countdown and both position checks are one pass of
// logic from the state registers to the next state and result registers, and
// req_ready stays high while the result register is empty or being emptied.
// process_ticks is written through csr_wr_en/csr_wr_data; write it only while idle (not enforced here).
module conveyor_diverter_sequencer #(
   parameter int SETTLE_MIN_TICKS = cds_pkg::SETTLE_MIN_TICKS_DEF,
   parameter int SETTLE_MAX_TICKS = cds_pkg::SETTLE_MAX_TICKS_DEF,
   parameter int TIMER_BITS       = cds_pkg::TIMER_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_device_running,
   input  logic       req_bag_detected,
   input  logic       req_verdict_write,
   input  logic [7:0] req_verdict_value,
   input  logic       req_outer_home_sensor,
   input  logic       req_inner_home_sensor,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_baffle_drive,
   output logic [1:0] rsp_actuate_event,
   output logic [1:0] rsp_clear_error_bits,
   output logic [1:0] rsp_settling,
   output logic       rsp_bag_in_window,
   output logic       rsp_bag_ok
);

   localparam int CB = cds_pkg::CFG_BITS;
   localparam int WB = (TIMER_BITS > CB) ? TIMER_BITS : CB;
   localparam logic [WB-1:0] TIMER_MAX = WB'({TIMER_BITS{1'b1}});

   logic [CB-1:0]         ptick_ff;
   logic [TIMER_BITS-1:0] scan_ff, scan_in;
   logic [TIMER_BITS-1:0] proc_ff, proc_in;
   logic                  window_ff, window_in;
   logic                  running_ff, running_in;
   logic                  ok_ff, ok_in;
   logic [7:0]            latch_ff, latch_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  drive_ff, drive_in;

   logic                  rsp_valid_ff;
   logic [1:0]            event_ff, event_in;
   logic [1:0]            clear_ff, clear_in;

   logic                  accept;
   logic [1:0]            mode_mid;
   logic                  outer_done, inner_done;
   logic [WB-1:0]         full_wide, win_wide;
   logic [TIMER_BITS-1:0] full_fit, win_fit;
   logic [CB-1:0]         win_raw;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // saturate process_ticks and the scan window to the timer width
   always_comb begin
      win_raw   = (ptick_ff > cds_pkg::SCAN_LEAD) ? (ptick_ff - cds_pkg::SCAN_LEAD) : '0;
      full_wide = WB'(ptick_ff);
      win_wide  = WB'(win_raw);
      full_fit  = (full_wide > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                          : full_wide[TIMER_BITS-1:0];
      win_fit   = (win_wide > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                         : win_wide[TIMER_BITS-1:0];
   end

   always_comb begin
      latch_in   = req_verdict_write ? req_verdict_value : latch_ff;
      scan_in    = scan_ff;
      proc_in    = proc_ff;
      window_in  = window_ff;
      running_in = running_ff;
      ok_in      = ok_ff;
      drive_in   = drive_ff;
      mode_mid   = mode_ff;
      event_in   = cds_pkg::EVT_NONE;
      clear_in   = cds_pkg::CLR_NONE;

      if (req_device_running) begin
         if (!window_in && req_bag_detected) begin
            scan_in    = win_fit;
            proc_in    = full_fit;
            window_in  = 1'b1;
            running_in = 1'b1;
         end
         if (window_in && (scan_in == '0)) begin
            ok_in     = (latch_in == cds_pkg::VERDICT_ACCEPT);
            latch_in  = '0;
            window_in = 1'b0;
         end
         if (proc_in == '0) begin
            if (ok_in) begin
               drive_in = cds_pkg::DRIVE_OUTER;
               mode_mid = cds_pkg::MODE_OUTER;
               event_in = cds_pkg::EVT_OUTER;
               clear_in = cds_pkg::CLR_OUTER;
            end else begin
               drive_in = cds_pkg::DRIVE_INNER;
               mode_mid = cds_pkg::MODE_INNER;
               event_in = cds_pkg::EVT_INNER;
               clear_in = cds_pkg::CLR_INNER;
            end
            proc_in    = full_fit;
            running_in = 1'b0;
         end
      end else begin
         window_in  = 1'b0;
         proc_in    = '0;
         running_in = 1'b0;
      end

      if (scan_in != '0) begin
         scan_in = scan_in - TIMER_BITS'(1);
      end
      if (running_in && (proc_in != '0)) begin
         proc_in = proc_in - TIMER_BITS'(1);
      end

      mode_in = mode_mid;
      if (((mode_mid == cds_pkg::MODE_OUTER) && outer_done) ||
          ((mode_mid == cds_pkg::MODE_INNER) && inner_done)) begin
         mode_in = cds_pkg::MODE_IDLE;
      end
   end

   cds_settle #(
      .SETTLE_MIN_TICKS(SETTLE_MIN_TICKS),
      .SETTLE_MAX_TICKS(SETTLE_MAX_TICKS)
   ) u_settle_outer (
      .clock  (clock),
      .reset  (reset),
      .advance(accept && (mode_mid == cds_pkg::MODE_OUTER)),
      .sensor (req_outer_home_sensor),
      .done   (outer_done)
   );

   cds_settle #(
      .SETTLE_MIN_TICKS(SETTLE_MIN_TICKS),
      .SETTLE_MAX_TICKS(SETTLE_MAX_TICKS)
   ) u_settle_inner (
      .clock  (clock),
      .reset  (reset),
      .advance(accept && (mode_mid == cds_pkg::MODE_INNER)),
      .sensor (req_inner_home_sensor),
      .done   (inner_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ptick_ff     <= cds_pkg::PROCESS_TICKS_RST;
         scan_ff      <= '0;
         proc_ff      <= '0;
         window_ff    <= 1'b0;
         running_ff   <= 1'b0;
         ok_ff        <= 1'b0;
         latch_ff     <= '0;
         mode_ff      <= cds_pkg::MODE_IDLE;
         drive_ff     <= cds_pkg::DRIVE_INNER;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ptick_ff <= csr_wr_data;
         end
         if (accept) begin
            scan_ff    <= scan_in;
            proc_ff    <= proc_in;
            window_ff  <= window_in;
            running_ff <= running_in;
            ok_ff      <= ok_in;
            latch_ff   <= latch_in;
            mode_ff    <= mode_in;
            drive_ff   <= drive_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // per-tick event fields; held while the result waits
   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff <= event_in;
         clear_ff <= clear_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_baffle_drive     = drive_ff;
   assign rsp_actuate_event    = event_ff;
   assign rsp_clear_error_bits = clear_ff;
   assign rsp_settling         = mode_ff;
   assign rsp_bag_in_window    = window_ff;
   assign rsp_bag_ok           = ok_ff;

endmodule

// ----- hdl/cds_checker.sv -----
// Port-level checker for the conveyor diverter sequencer, bound to the top level.
// Depends on cds_pkg and conveyor_diverter_sequencer_defines.svh.
`include "conveyor_diverter_sequencer_defines.svh"

module cds_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_baffle_drive,
   input logic [1:0] rsp_actuate_event,
   input logic [1:0] rsp_clear_error_bits,
   input logic [1:0] rsp_settling,
   input logic       rsp_bag_in_window,
   input logic       rsp_bag_ok
);

   // an outer firing drives outer and clears the outer error only
   `CDS_ASSERT_NOW(a_outer_fire, clock, reset,
      rsp_valid && (rsp_actuate_event == cds_pkg::EVT_OUTER),
      (rsp_baffle_drive == cds_pkg::DRIVE_OUTER) &&
      (rsp_clear_error_bits == cds_pkg::CLR_OUTER) && rsp_bag_ok,
      "outer firing inconsistent")

   `CDS_ASSERT_NOW(a_inner_fire, clock, reset,
      rsp_valid && (rsp_actuate_event == cds_pkg::EVT_INNER),
      (rsp_baffle_drive == cds_pkg::DRIVE_INNER) &&
      (rsp_clear_error_bits == cds_pkg::CLR_INNER) && !rsp_bag_ok,
      "inner firing inconsistent")

   // error bits are cleared only on a firing tick
   `CDS_ASSERT_NOW(a_clear_only_on_fire, clock, reset,
      rsp_valid && (rsp_actuate_event == cds_pkg::EVT_NONE),
      rsp_clear_error_bits == cds_pkg::CLR_NONE,
      "error clear without firing")

   `CDS_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_baffle_drive) && $stable(rsp_actuate_event) &&
      $stable(rsp_clear_error_bits) && $stable(rsp_settling) &&
      $stable(rsp_bag_in_window) && $stable(rsp_bag_ok),
      "stalled transaction changed")

endmodule

bind conveyor_diverter_sequencer cds_checker u_cds_checker (.*);
